// ----- hw/rtl/zef_pkg.sv -----
// ----------------------------------------------------------------------------
// zef_pkg - shared types and constants of the extra-field scrubber
// Transaction payloads, configuration bundle, status codes and register map.
// ----------------------------------------------------------------------------
package zef_pkg;

	// one raw byte of the extra-data field
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// one rewritten byte with end-of-field status
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [1:0] status;
	} out_item_t;

	// configuration registers as seen by the parser
	typedef struct packed {
		logic [15:0] scrub_id_first;
		logic [15:0] scrub_id_second;
		logic [15:0] marker_id;
		logic [7:0]  fill_byte;
	} cfg_t;

	// up to two results produced by one input byte
	typedef struct packed {
		logic      push0;
		logic      push1;
		out_item_t res0;
		out_item_t res1;
	} res_pair_t;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	// register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_SCRUB_FIRST  = 2'd0;
	localparam logic [1:0] REG_SCRUB_SECOND = 2'd1;
	localparam logic [1:0] REG_MARKER       = 2'd2;
	localparam logic [1:0] REG_FILL         = 2'd3;

	localparam int ADDR_W = 4;

	// register reset values
	localparam logic [15:0] RST_SCRUB_FIRST  = 16'h5455;
	localparam logic [15:0] RST_SCRUB_SECOND = 16'h7875;
	localparam logic [15:0] RST_MARKER       = 16'hFFFF;
	localparam logic [7:0]  RST_FILL         = 8'hFF;

	// result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ----- hw/rtl/zip_extra_field_scrubber.sv -----
// ----------------------------------------------------------------------------
// zip_extra_field_scrubber - ZIP extra-data field scrubber
// Rewrites selected records of an extra-data field byte by byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------
//  in      | input     | in_valid/in_ready | in_data (data_byte, last_byte)
//  out     | output    | out_valid/ready   | out_data (out_byte, last, status)
//  cfg     | input     | psel/penable      | paddr, pwdata, prdata
//
// One byte is accepted per cycle while in_ready is high; the parser state
// updates on acceptance and its 0, 1 or 2 results enter a four-entry result
// queue, whose registers hold them until read out. The queue's single output
// port limits the stream to one result per cycle. in_ready drops while fewer
// than two entries are free. Reset empties parser and queue, resets registers.
// ----------------------------------------------------------------------------
module zip_extra_field_scrubber (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  zef_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output zef_pkg::out_item_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [zef_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	zef_pkg::cfg_t      cfg;
	zef_pkg::res_pair_t res;
	logic               take;

	assign take = in_valid & in_ready;

	// configuration registers
	zef_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// record parser
	zef_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_data),
		.cfg    (cfg),
		.res    (res)
	);

	// result queue
	zef_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res       (res),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/zef_regs.sv -----
// ----------------------------------------------------------------------------
// zef_regs - configuration register file
// APB-style write/read access to the scrub ids, marker id and fill byte.
// ----------------------------------------------------------------------------
module zef_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [zef_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output zef_pkg::cfg_t              cfg
);

	zef_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scrub_id_first  <= zef_pkg::RST_SCRUB_FIRST;
			cfg_q.scrub_id_second <= zef_pkg::RST_SCRUB_SECOND;
			cfg_q.marker_id       <= zef_pkg::RST_MARKER;
			cfg_q.fill_byte       <= zef_pkg::RST_FILL;
		end else if (wr_en) begin
			case (idx)
				zef_pkg::REG_SCRUB_FIRST:  cfg_q.scrub_id_first  <= pwdata[15:0];
				zef_pkg::REG_SCRUB_SECOND: cfg_q.scrub_id_second <= pwdata[15:0];
				zef_pkg::REG_MARKER:       cfg_q.marker_id       <= pwdata[15:0];
				zef_pkg::REG_FILL:         cfg_q.fill_byte       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			zef_pkg::REG_SCRUB_FIRST:  prdata = {16'd0, cfg_q.scrub_id_first};
			zef_pkg::REG_SCRUB_SECOND: prdata = {16'd0, cfg_q.scrub_id_second};
			zef_pkg::REG_MARKER:       prdata = {16'd0, cfg_q.marker_id};
			zef_pkg::REG_FILL:         prdata = {24'd0, cfg_q.fill_byte};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/zef_parse.sv -----
// ----------------------------------------------------------------------------
// zef_parse - record parser and rewriter
// Tracks the record header/payload position and produces up to two results
// for each accepted byte.
// ----------------------------------------------------------------------------
module zef_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  zef_pkg::in_item_t    item,
	input  zef_pkg::cfg_t        cfg,
	output zef_pkg::res_pair_t   res
);

	localparam logic [2:0] PH_ID_LO   = 3'd0;
	localparam logic [2:0] PH_ID_HI   = 3'd1;
	localparam logic [2:0] PH_LEN_LO  = 3'd2;
	localparam logic [2:0] PH_LEN_HI  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_PASS    = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] left_q, left_d;
	logic        scrub_q, scrub_d;

	logic [15:0] rec_id;
	logic [15:0] rec_len;
	logic [15:0] left_dec;
	logic        b_last;
	logic [1:0]  st;

	assign rec_id   = {item.data_byte, held_q};
	assign rec_len  = {item.data_byte, len_lo_q};
	assign left_dec = left_q - 16'd1;
	assign b_last   = item.last_byte;

	// next state and results
	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		len_lo_d = len_lo_q;
		left_d   = left_q;
		scrub_d  = scrub_q;
		st       = zef_pkg::ST_OK;
		res      = '0;
		case (phase_q)
			PH_ID_HI: begin
				res.push0         = 1'b1;
				res.push1         = 1'b1;
				res.res0.out_byte = held_q;
				res.res1.out_byte = item.data_byte;
				if (rec_id == cfg.scrub_id_first || rec_id == cfg.scrub_id_second) begin
					scrub_d           = 1'b1;
					res.res0.out_byte = cfg.marker_id[7:0];
					res.res1.out_byte = cfg.marker_id[15:8];
					phase_d           = PH_LEN_LO;
					st                = zef_pkg::ST_TRUNC;
				end else if (rec_id == cfg.marker_id) begin
					scrub_d = 1'b0;
					phase_d = PH_LEN_LO;
					st      = zef_pkg::ST_TRUNC;
				end else begin
					phase_d = PH_PASS;
					st      = zef_pkg::ST_UNKNOWN;
				end
				res.res1.out_last = b_last;
				res.res1.status   = b_last ? st : zef_pkg::ST_OK;
			end
			PH_LEN_LO: begin
				len_lo_d          = item.data_byte;
				phase_d           = PH_LEN_HI;
				res.push0         = 1'b1;
				res.res0.out_byte = item.data_byte;
				res.res0.out_last = b_last;
				res.res0.status   = b_last ? zef_pkg::ST_TRUNC : zef_pkg::ST_OK;
			end
			PH_LEN_HI: begin
				left_d            = rec_len;
				phase_d           = (rec_len == 16'd0) ? PH_ID_LO : PH_PAYLOAD;
				st                = (rec_len == 16'd0) ? zef_pkg::ST_OK : zef_pkg::ST_TRUNC;
				res.push0         = 1'b1;
				res.res0.out_byte = item.data_byte;
				res.res0.out_last = b_last;
				res.res0.status   = b_last ? st : zef_pkg::ST_OK;
			end
			PH_PAYLOAD: begin
				left_d            = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_ID_LO;
				end
				st                = (left_dec == 16'd0) ? zef_pkg::ST_OK : zef_pkg::ST_TRUNC;
				res.push0         = 1'b1;
				res.res0.out_byte = scrub_q ? cfg.fill_byte : item.data_byte;
				res.res0.out_last = b_last;
				res.res0.status   = b_last ? st : zef_pkg::ST_OK;
			end
			PH_PASS: begin
				res.push0         = 1'b1;
				res.res0.out_byte = item.data_byte;
				res.res0.out_last = b_last;
				res.res0.status   = b_last ? zef_pkg::ST_UNKNOWN : zef_pkg::ST_OK;
			end
			default: begin
				// id low byte: held back unless the field ends here
				if (b_last) begin
					res.push0         = 1'b1;
					res.res0.out_byte = item.data_byte;
					res.res0.out_last = 1'b1;
					res.res0.status   = zef_pkg::ST_TRUNC;
				end else begin
					held_d  = item.data_byte;
					phase_d = PH_ID_HI;
				end
			end
		endcase
		// end of field: back to the start
		if (b_last) begin
			phase_d  = PH_ID_LO;
			held_d   = 8'd0;
			len_lo_d = 8'd0;
			left_d   = 16'd0;
			scrub_d  = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID_LO;
			held_q   <= 8'd0;
			len_lo_q <= 8'd0;
			left_q   <= 16'd0;
			scrub_q  <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			held_q   <= held_d;
			len_lo_q <= len_lo_d;
			left_q   <= left_d;
			scrub_q  <= scrub_d;
		end
	end

endmodule

// ----- hw/rtl/zef_out_queue.sv -----
// ----------------------------------------------------------------------------
// zef_out_queue - result queue
// Small register queue taking up to two results per cycle and giving one.
// ----------------------------------------------------------------------------
module zef_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  zef_pkg::res_pair_t   res,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output zef_pkg::out_item_t   out_data
);

	zef_pkg::out_item_t               mem_q [zef_pkg::QDEPTH];
	logic [zef_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [zef_pkg::QCNT_W-1:0]       cnt_q;
	logic                             push0, push1, pop;

	assign push0     = take & res.push0;
	assign push1     = take & res.push1;
	assign pop       = out_valid & out_ready;
	assign wr_ptr_p1 = wr_ptr_q + zef_pkg::QPTR_W'(1);

	// room for two more results
	assign room      = cnt_q <= zef_pkg::QCNT_W'(zef_pkg::QDEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= res.res0;
		end
		if (push1) begin
			mem_q[wr_ptr_p1] <= res.res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + zef_pkg::QPTR_W'(push0) + zef_pkg::QPTR_W'(push1);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + zef_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + zef_pkg::QCNT_W'(push0) + zef_pkg::QCNT_W'(push1)
				- zef_pkg::QCNT_W'(pop);
		end
	end

endmodule
